// ----- src/lpot_pkg.sv -----
// Shared widths, register indexes, confidence constants and control types of the lane tracker.
package lpot_pkg;

  localparam int LANE_W     = 13;
  localparam int SCREEN_W   = 14;
  localparam int FW_W       = 12;
  localparam int WL_W       = 5;
  localparam int CONF_W     = 7;
  localparam int FILL_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 12'd640;
  localparam logic [WL_W-1:0] WINDOW_LENGTH_RST = 5'd8;

  // Edge margin in screen pixels, and closeness limit for the single stored sample
  localparam int EDGE_MARGIN = 5;
  localparam int NEAR_LIMIT  = 5;

  // Confidence in percent
  localparam logic [CONF_W:0]   CONF_UP     = 8'd35;
  localparam logic [CONF_W:0]   CONF_MAX_X  = 8'd100;
  localparam logic [CONF_W-1:0] CONF_MAX    = 7'd100;
  localparam logic [CONF_W-1:0] CONF_DOWN   = 7'd2;
  localparam logic [CONF_W-1:0] CONF_STABLE = 7'd50;

  // Control of the window accumulator
  typedef struct packed {
    logic clr;
    logic en;
  } acc_ctl_t;

endpackage

// ----- src/lpot_in_if.sv -----
// Input channel: one lane sample per transfer.
interface lpot_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpot_pkg::LANE_W-1:0]   lane_x;
  logic signed [lpot_pkg::SCREEN_W-1:0] screen_x;

  modport source (output valid, output lane_x, output screen_x, input ready);
  modport sink   (input valid, input lane_x, input screen_x, output ready);
endinterface

// ----- src/lpot_out_if.sv -----
// Result channel: tracked position and confidence per transfer.
interface lpot_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpot_pkg::LANE_W-1:0] position;
  logic [lpot_pkg::CONF_W-1:0]        confidence_out;
  logic                               stable;
  logic [lpot_pkg::FILL_W-1:0]        fill_count;

  modport source (output valid, output position, output confidence_out, output stable,
                  output fill_count, input ready);
  modport sink   (input valid, input position, input confidence_out, input stable,
                  input fill_count, output ready);
endinterface

// ----- src/lpot_cfg_if.sv -----
// Configuration write channel.
interface lpot_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpot_pkg::CFG_IDX_W-1:0]      index;
  logic [lpot_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/lpot_acc.sv -----
// Window accumulator: sum, sum of squares and fourth-power weighted sum over a sample stream.
module lpot_acc #(
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  lpot_pkg::acc_ctl_t                      ctl,
  input  logic signed [lpot_pkg::LANE_W-1:0]      sample,
  output logic signed [lpot_pkg::LANE_W+$clog2(DEPTH)-1:0]    sum,
  output logic [2*lpot_pkg::LANE_W-1+$clog2(DEPTH)-1:0]       sqsum,
  output logic signed [5*$clog2(DEPTH)+lpot_pkg::LANE_W:0]     wacc,
  output logic [5*$clog2(DEPTH)-1:0]                          wsum
);

  localparam int LW  = $clog2(DEPTH);
  localparam int SW  = lpot_pkg::LANE_W + LW;
  localparam int QW  = 2 * lpot_pkg::LANE_W - 1 + LW;
  localparam int SQ  = 2 * lpot_pkg::LANE_W;
  localparam int WW  = 4 * LW;
  localparam int WSW = WW + LW;
  localparam int AW  = WW + lpot_pkg::LANE_W + LW + 1;

  logic [LW-1:0]                        idx;
  logic [2*LW-1:0]                      sq;
  logic [WW-1:0]                        w;
  logic signed [lpot_pkg::LANE_W-1:0]   d1;
  logic                                 v1;

  // Stage 1: weight i^4 from the running square; stage 2: accumulate
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      idx   <= '0;
      sq    <= '0;
      v1    <= 1'b0;
      sum   <= '0;
      sqsum <= '0;
      wacc  <= '0;
      wsum  <= '0;
    end else begin
      v1 <= ctl.en;
      if (ctl.en) begin
        d1  <= sample;
        w   <= WW'(sq) * WW'(sq);
        idx <= idx + LW'(1);
        sq  <= sq + (2*LW)'({idx, 1'b1});
      end
      if (v1) begin
        sum   <= sum + SW'(d1);
        sqsum <= sqsum + QW'($unsigned(SQ'(d1) * SQ'(d1)));
        wacc  <= wacc + AW'($signed({1'b0, w})) * AW'(d1);
        wsum  <= wsum + WSW'(w);
      end
    end
  end

endmodule

// ----- src/lpot_div.sv -----
// Bit-serial restoring divider: signed dividend over positive divisor, truncated toward zero.
module lpot_div #(
  parameter int AW = 34,
  parameter int BW = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [AW-1:0]               dividend,
  input  logic [BW-1:0]                      divisor,
  output logic                               done,
  output logic signed [lpot_pkg::LANE_W-1:0] quotient
);

  localparam int CNTW = $clog2(AW + 1);

  logic [BW:0]      rem;
  logic [AW-1:0]    quo;
  logic [BW-1:0]    dvs;
  logic [CNTW-1:0]  cnt;
  logic             neg;
  logic             run;
  logic [BW:0]      rem_sh;
  logic             take;

  // One quotient bit per cycle
  assign rem_sh = {rem[BW-1:0], quo[AW-1]};
  assign take   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(AW);
        rem <= '0;
        dvs <= divisor;
        neg <= dividend[AW-1];
        quo <= dividend[AW-1] ? $unsigned(-dividend) : $unsigned(dividend);
      end else if (run) begin
        rem <= take ? rem_sh - {1'b0, dvs} : rem_sh;
        quo <= {quo[AW-2:0], take};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Magnitude fits the lane width; apply the sign
  assign quotient = neg ? -$signed(quo[lpot_pkg::LANE_W-1:0])
                        : $signed(quo[lpot_pkg::LANE_W-1:0]);

endmodule

// ----- src/lane_position_outlier_tracker.sv -----
// Lane position tracker top level: sample window, outlier tests, confidence and result.
//
// One sample is taken at a time. The window memory is walked twice, one read
// a cycle (before the update for the outlier test, after it for the result),
// and the weighted average comes out of a one-bit-per-cycle divider of
// 5*log2(WINDOW_DEPTH) + 14 steps. A result stalled at the output holds the
// next one in its last state until the output frees up.
// A new sample is taken while the previous result still waits to be read.
// window_length 0 acts as 1 and values above WINDOW_DEPTH act as
// WINDOW_DEPTH; shrinking it below the fill count drops the oldest samples
// at once. Configuration is to be written only while no sample is in flight;
// the block itself does not enforce this.
module lane_position_outlier_tracker #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  lpot_in_if.sink    samples,
  lpot_out_if.source results,
  lpot_cfg_if.sink   cfg
);

  localparam int LW   = $clog2(WINDOW_DEPTH);
  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int IW   = $clog2(WINDOW_DEPTH + 2);
  localparam int SW   = lpot_pkg::LANE_W + LW;
  localparam int QW   = 2 * lpot_pkg::LANE_W - 1 + LW;
  localparam int WW   = 4 * LW;
  localparam int WSW  = WW + LW;
  localparam int AW   = WW + lpot_pkg::LANE_W + LW + 1;
  localparam int NQW  = QW + CW;
  localparam int SSW  = 2 * SW;
  localparam int TW   = SW + CW + 2;
  localparam int TTW  = 2 * TW;
  localparam int D25W = NQW + 5;
  localparam int CMW  = TTW + D25W + 2;
  localparam int LN   = lpot_pkg::LANE_W;

  localparam logic signed [TW-1:0] NEAR_P = TW'(lpot_pkg::NEAR_LIMIT);
  localparam logic signed [TW-1:0] NEAR_N = -NEAR_P;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_SCALE = 8'b0001_0000,
    S_UPD   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [lpot_pkg::FW_W-1:0]       frame_width;
  logic [lpot_pkg::WL_W-1:0]       window_length;

  logic signed [LN-1:0]            mem [WINDOW_DEPTH];
  logic signed [LN-1:0]            rd_data;
  logic [LW-1:0]                   rd_addr;
  logic                            rd_vld;
  logic [LW-1:0]                   wr_addr;
  logic                            wr_en;

  logic [LW-1:0]                   head;
  logic [CW-1:0]                   count;
  logic [lpot_pkg::CONF_W-1:0]     conf;
  logic signed [LN-1:0]            v_q;
  logic                            rej_q;
  logic                            pass;
  logic [IW-1:0]                   idx;

  logic signed [SW-1:0]            s_sum;
  logic [QW-1:0]                   q_sum;
  logic signed [AW-1:0]            w_acc;
  logic [WSW-1:0]                  w_sum;
  lpot_pkg::acc_ctl_t              acc_ctl;

  logic [NQW-1:0]                  p_nq;
  logic [SSW-1:0]                  p_ss;
  logic signed [TW-1:0]            p_nv;
  logic [NQW-1:0]                  d;
  logic signed [TW-1:0]            t;
  logic [TTW-1:0]                  p_tt;
  logic [D25W-1:0]                 p_25d;

  logic                            res_stable;
  logic signed [LN-1:0]            res_pos;
  logic                            div_start;
  logic                            div_done;
  logic signed [LN-1:0]            div_q;

  logic                            in_xfer;
  logic                            cfg_xfer;
  logic [CW-1:0]                   eff_len;
  logic [CW-1:0]                   new_len;
  logic                            stable_now;
  logic                            fit;
  logic                            near;
  logic                            lose;
  logic                            store_go;
  logic                            full;
  logic [lpot_pkg::CONF_W:0]       conf_up;
  logic signed [LN-1:0]            half_fw;
  logic signed [lpot_pkg::SCREEN_W:0] sx_ext;
  logic signed [lpot_pkg::SCREEN_W:0] sx_hi;
  logic                            reject_in;

  // Window length clamped to 1..WINDOW_DEPTH
  function automatic logic [CW-1:0] clamp_len(input logic [lpot_pkg::WL_W-1:0] wl);
    logic [CW-1:0] r;
    if (wl == '0) r = CW'(1);
    else if (32'(wl) > WINDOW_DEPTH) r = CW'(WINDOW_DEPTH);
    else r = CW'(wl);
    return r;
  endfunction

  // Ring pointer modulo the depth; argument stays below twice the depth
  function automatic logic [LW-1:0] wrap(input logic [LW:0] x);
    logic [LW-1:0] r;
    if (x >= (LW+1)'(WINDOW_DEPTH)) r = LW'(x - (LW+1)'(WINDOW_DEPTH));
    else r = LW'(x);
    return r;
  endfunction

  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_xfer       = samples.valid && samples.ready;
  assign cfg_xfer      = cfg.valid && cfg.ready;
  assign eff_len       = clamp_len(window_length);
  assign new_len       = clamp_len(cfg.data[lpot_pkg::WL_W-1:0]);

  // Center and edge rejection on the incoming sample
  assign half_fw   = $signed({2'b00, frame_width[lpot_pkg::FW_W-1:1]});
  assign sx_ext    = (lpot_pkg::SCREEN_W+1)'(samples.screen_x);
  assign sx_hi     = $signed({3'b000, frame_width})
                     - (lpot_pkg::SCREEN_W+1)'(lpot_pkg::EDGE_MARGIN);
  assign reject_in = (samples.lane_x == half_fw)
                     || (sx_ext < (lpot_pkg::SCREEN_W+1)'(lpot_pkg::EDGE_MARGIN))
                     || (sx_ext > sx_hi);

  // Outlier and stability tests on the registered statistics
  assign stable_now = (count >= CW'(2)) && (conf > lpot_pkg::CONF_STABLE)
                      && (s_sum > SW'(0)) && (CMW'({p_25d, 2'b00}) < CMW'(p_ss));
  assign fit        = CMW'(p_tt) <= CMW'(p_25d);
  assign near       = (t < NEAR_P) && (t > NEAR_N);
  assign lose       = rej_q || ((count >= CW'(2)) && !fit);
  assign store_go   = !lose && ((count != CW'(1)) || near);
  assign full       = count >= eff_len;
  assign conf_up    = {1'b0, conf} + lpot_pkg::CONF_UP;
  assign wr_en      = (state == S_UPD) && !pass && store_go;
  assign wr_addr    = wrap((LW+1)'(head) + (LW+1)'(count));
  assign rd_addr    = wrap((LW+1)'(head) + (LW+1)'(idx[LW-1:0]));

  assign acc_ctl.clr = in_xfer || ((state == S_UPD) && !pass);
  assign acc_ctl.en  = rd_vld;
  assign div_start   = (state == S_UPD) && pass && (count >= CW'(2));

  // Sample memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= v_q;
    end
    rd_data <= mem[rd_addr];
  end

  lpot_acc #(.DEPTH(WINDOW_DEPTH)) u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .sample (rd_data),
    .sum    (s_sum),
    .sqsum  (q_sum),
    .wacc   (w_acc),
    .wsum   (w_sum)
  );

  lpot_div #(.AW(AW), .BW(WSW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (w_acc),
    .divisor  (w_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  // Statistics products and differences, at most one multiply per register
  always_ff @(posedge clk) begin
    case (state)
      S_MUL: begin
        p_nq <= NQW'(count) * NQW'(q_sum);
        p_ss <= $unsigned(SSW'(s_sum) * SSW'(s_sum));
        p_nv <= $signed(TW'({1'b0, count})) * TW'(v_q);
      end
      S_DIFF: begin
        d <= p_nq - NQW'(p_ss);
        t <= TW'(s_sum) - p_nv;
      end
      S_SCALE: begin
        p_tt  <= $unsigned(TTW'(t) * TTW'(t));
        p_25d <= D25W'({d, 4'b0000}) + D25W'({d, 3'b000}) + D25W'(d);
      end
      default: ;
    endcase
  end

  // Sequencer, window pointers, confidence and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_width    <= lpot_pkg::FRAME_WIDTH_RST;
      window_length  <= lpot_pkg::WINDOW_LENGTH_RST;
      head           <= '0;
      count          <= '0;
      conf           <= '0;
      pass           <= 1'b0;
      rd_vld         <= 1'b0;
      idx            <= '0;
      results.valid  <= 1'b0;
    end else begin
      rd_vld <= (state == S_WALK) && (idx < IW'(count));
      // Result leaves unless a new one is loaded in the same cycle
      if (results.valid && results.ready && (state != S_DONE)) begin
        results.valid <= 1'b0;
      end
      if (cfg_xfer) begin
        case (cfg.index)
          lpot_pkg::CFG_FRAME_WIDTH: frame_width <= cfg.data;
          lpot_pkg::CFG_WINDOW_LENGTH: begin
            window_length <= cfg.data[lpot_pkg::WL_W-1:0];
            if (count > new_len) begin
              head  <= wrap((LW+1)'(head) + (LW+1)'(count - new_len));
              count <= new_len;
            end
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            v_q   <= samples.lane_x;
            rej_q <= reject_in;
            pass  <= 1'b0;
            idx   <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          idx <= idx + IW'(1);
          if (idx == IW'(count) + IW'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_DIFF;
        S_DIFF:  state <= S_SCALE;
        S_SCALE: state <= S_UPD;
        S_UPD: begin
          if (!pass) begin
            // Window and confidence update
            if (lose) begin
              if (stable_now) begin
                conf <= conf - lpot_pkg::CONF_DOWN;
              end else begin
                count <= '0;
                conf  <= '0;
              end
            end else if (store_go) begin
              if (full) head <= wrap((LW+1)'(head) + (LW+1)'(1));
              else count <= count + CW'(1);
              if (count >= CW'(2)) begin
                conf <= (conf_up > lpot_pkg::CONF_MAX_X) ? lpot_pkg::CONF_MAX
                                                          : conf_up[lpot_pkg::CONF_W-1:0];
              end
            end else begin
              head  <= wrap((LW+1)'(head) + (LW+1)'(1));
              count <= count - CW'(1);
            end
            pass  <= 1'b1;
            idx   <= '0;
            state <= S_WALK;
          end else begin
            // Result of the updated window
            res_stable <= stable_now;
            if (count == '0) begin
              res_pos <= '0;
              state   <= S_DONE;
            end else if (count == CW'(1)) begin
              res_pos <= LN'(s_sum);
              state   <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_pos <= div_q;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid          <= 1'b1;
            results.position       <= res_pos;
            results.confidence_out <= conf;
            results.stable         <= res_stable;
            results.fill_count     <= lpot_pkg::FILL_W'(count);
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/lpot_checker.sv -----
// Port-level checks of the lane tracker results, bound to the top level.
module lpot_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lpot_pkg::LANE_W-1:0] position,
  input logic [lpot_pkg::CONF_W-1:0]        confidence_out,
  input logic                               stable,
  input logic [lpot_pkg::FILL_W-1:0]        fill_count
);

  // A pending result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(fill_count))
    else $error("result changed while stalled");

  // Confidence never passes its cap
  a_conf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> confidence_out <= lpot_pkg::CONF_MAX)
    else $error("confidence above cap");

  // Stable needs two samples and more than half confidence
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && stable |-> fill_count >= 5'd2 && confidence_out > lpot_pkg::CONF_STABLE)
    else $error("stable without support");

  // Empty window reports position zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill_count == '0 |-> position == '0)
    else $error("empty window with nonzero position");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lane_position_outlier_tracker lpot_checker u_lpot_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .position       (results.position),
  .confidence_out (results.confidence_out),
  .stable         (results.stable),
  .fill_count     (results.fill_count)
);
